>>> hdl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared definitions of the first-fit run allocator
// Word geometry of the slot bitmap, request and status codes, and the
// controller state type.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int SLOTS_DEFAULT    = 1024;
  localparam int SLOT_COUNT_RESET = 1024;

  // One bitmap word holds this many slots; a set bit marks a busy slot.
  localparam int WORD_W   = 16;
  localparam int WORD_LOG = 4;

  // Fixed field widths of the request and result items.
  localparam int LEN_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 11;
  localparam int STAT_W  = 2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } ffra_state_t;

endpackage

>>> hdl/first_fit_run_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_run_allocator_top: first-fit allocator of contiguous slot runs
// An allocate scans the bitmap words and then marks each word of the granted
// run with a read and a write; a release only marks its range; a bad request
// or a length beyond slot_count goes straight to the result.
// One item is worked at a time; the single bitmap RAM port pair sets the pace.
// Reset or a slot_count write starts a clearing pass over every bitmap word,
// during which no item is accepted.
// ----------------------------------------------------------------------------
module first_fit_run_allocator_top
  import ffra_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: slot_count.
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  // Requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // run_length[10:0], first_slot[20:11], last_slot[30:21]
  input  logic        in_tuser,   // operation
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // start_slot[9:0], granted[10], status[12:11]
);

  // The map is a bitmap of 16-slot words in one RAM, a set bit meaning busy.
  // An allocate streams the words through a run finder, carrying the free
  // run across word boundaries, which gives the lowest fitting start. The
  // granted or released range is then written back word by word with a
  // read-modify-write. Slots at or beyond slot_count are seen as busy.

  localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = AW + WORD_LOG;
  localparam int CNTW  = $clog2(SLOTS + 1);
  localparam int RESET_COUNT = (SLOT_COUNT_RESET > SLOTS) ? SLOTS : SLOT_COUNT_RESET;

  ffra_state_t state_r, state_nxt;

  logic [CNTW-1:0]   count_r, count_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     iss_r, iss_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_word_r, pend_word_nxt;
  logic [CNTW-1:0]   carry_r, carry_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic              mark_v_r, mark_v_nxt;
  logic [AW-1:0]     mword_r, mword_nxt;
  logic [PW-1:0]     res_start_r, res_start_nxt;
  logic              res_grant_r, res_grant_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [15:0]       out_tdata_r, out_tdata_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [WORD_W-1:0] busy_eff, merged;
  logic              sc_found;
  logic [WORD_LOG-1:0] sc_bit;
  logic [CNTW-1:0]   sc_carry;

  logic [LEN_W-1:0]  in_len;
  logic [SLOT_W-1:0] in_first, in_last;
  logic [AW-1:0]     last_word;
  logic [CNTW-1:0]   cfg_count;
  logic [PW-1:0]     fit_start;

  assign in_len   = in_tdata[10:0];
  assign in_first = in_tdata[20:11];
  assign in_last  = in_tdata[30:21];

  assign last_word = AW'(PW'(count_r - CNTW'(1)) >> WORD_LOG);

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_count = CNTW'(1);
    end else if (32'(cfg_wr_data) > 32'(SLOTS)) begin
      cfg_count = CNTW'(SLOTS);
    end else begin
      cfg_count = CNTW'(cfg_wr_data);
    end
  end

  ffra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slots past slot_count never belong to a free run.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      busy_eff[i] = ram_rdata[i] |
                    (32'({pend_word_r, WORD_LOG'(i)}) >= 32'(count_r));
    end
  end

  ffra_scan #(
    .CNTW (CNTW)
  ) u_scan (
    .busy      (busy_eff),
    .carry_in  (carry_r),
    .want      (len_r),
    .found     (sc_found),
    .found_bit (sc_bit),
    .carry_out (sc_carry)
  );

  assign fit_start = {pend_word_r, sc_bit} + PW'(1) - PW'(len_r);

  always_comb begin
    logic [PW-1:0] pos;
    for (int i = 0; i < WORD_W; i++) begin
      pos = {mword_r, WORD_LOG'(i)};
      merged[i] = (pos >= lo_r && pos <= hi_r) ? mark_v_r : ram_rdata[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      count_r      <= CNTW'(RESET_COUNT);
      clr_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      clr_r        <= clr_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r       <= iss_nxt;
    iss_done_r  <= iss_done_nxt;
    pend_word_r <= pend_word_nxt;
    carry_r     <= carry_nxt;
    len_r       <= len_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mark_v_r    <= mark_v_nxt;
    mword_r     <= mword_nxt;
    res_start_r <= res_start_nxt;
    res_grant_r <= res_grant_nxt;
    res_stat_r  <= res_stat_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    iss_nxt        = iss_r;
    iss_done_nxt   = iss_done_r;
    pend_nxt       = 1'b0;
    pend_word_nxt  = pend_word_r;
    carry_nxt      = carry_r;
    len_nxt        = len_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mark_v_nxt     = mark_v_r;
    mword_nxt      = mword_r;
    res_start_nxt  = res_start_r;
    res_grant_nxt  = res_grant_r;
    res_stat_nxt   = res_stat_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = mword_r;
    ram_wdata      = merged;
    ram_raddr      = mword_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (32'(clr_r) == WORDS - 1) begin
          clr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        in_tready     = 1'b1;
        res_start_nxt = '0;
        res_grant_nxt = 1'b0;
        res_stat_nxt  = STAT_OK;
        if (in_tvalid) begin
          if (in_tuser == OP_ALLOC) begin
            len_nxt = in_len;
            if (in_len == '0) begin
              res_stat_nxt = STAT_BAD;
              state_nxt    = ST_DONE;
            end else if (32'(in_len) > 32'(count_r)) begin
              res_stat_nxt = STAT_NOFIT;
              state_nxt    = ST_DONE;
            end else begin
              iss_nxt      = '0;
              iss_done_nxt = 1'b0;
              carry_nxt    = '0;
              state_nxt    = ST_SCAN;
            end
          end else begin
            if (in_first > in_last || 32'(in_last) >= 32'(count_r)) begin
              res_stat_nxt = STAT_BAD;
              state_nxt    = ST_DONE;
            end else begin
              lo_nxt     = PW'(in_first);
              hi_nxt     = PW'(in_last);
              mark_v_nxt = 1'b0;
              mword_nxt  = AW'(PW'(in_first) >> WORD_LOG);
              state_nxt  = ST_MARK_RD;
            end
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued one word a cycle; the data is judged in the cycle after.
        ram_raddr = iss_r;
        if (!iss_done_r) begin
          pend_nxt      = 1'b1;
          pend_word_nxt = iss_r;
          if (iss_r == last_word) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_nxt = iss_r + AW'(1);
          end
        end
        if (pend_r) begin
          carry_nxt = sc_carry;
          if (sc_found) begin
            pend_nxt      = 1'b0;
            res_start_nxt = fit_start;
            res_grant_nxt = 1'b1;
            lo_nxt        = fit_start;
            hi_nxt        = fit_start + PW'(len_r) - PW'(1);
            mark_v_nxt    = 1'b1;
            mword_nxt     = AW'(fit_start >> WORD_LOG);
            state_nxt     = ST_MARK_RD;
          end else if (pend_word_r == last_word) begin
            pend_nxt     = 1'b0;
            res_stat_nxt = STAT_NOFIT;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_MARK_RD: begin
        state_nxt = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        ram_we = 1'b1;
        if (mword_r == AW'(hi_r >> WORD_LOG)) begin
          state_nxt = ST_DONE;
        end else begin
          mword_nxt = mword_r + AW'(1);
          state_nxt = ST_MARK_RD;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, res_stat_r, res_grant_r,
                            res_grant_r ? SLOT_W'(res_start_r) : SLOT_W'(0)};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // A size write restarts the map from all free.
    if (cfg_wr_en) begin
      count_nxt = cfg_count;
      clr_nxt   = '0;
      state_nxt = ST_CLEAR;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A size write always blocks requests until the clearing pass is over.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("request accepted right after a size write");

  // A granted run starts inside the managed slots.
  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (32'(out_tdata[9:0]) < 32'(count_r)))
    else $error("granted start beyond slot_count");

  // Only a successful allocate reports a grant.
  a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (out_tdata[12:11] == STAT_OK))
    else $error("grant with a failing status");

  // Each result follows the end of a request's work.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the finishing state");

endmodule

>>> hdl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ffra_scan.sv
// ----------------------------------------------------------------------------
// ffra_scan: free-run search over one bitmap word
// Extends the free run carried in from lower words and finds the lowest bit
// at which a run of the wanted length is complete.
// ----------------------------------------------------------------------------
module ffra_scan
  import ffra_pkg::*;
#(
  parameter int CNTW = 11
) (
  input  logic [WORD_W-1:0]   busy,
  input  logic [CNTW-1:0]     carry_in,
  input  logic [LEN_W-1:0]    want,
  output logic                found,
  output logic [WORD_LOG-1:0] found_bit,
  output logic [CNTW-1:0]     carry_out
);

  localparam int RW   = CNTW + 1;
  localparam int CMPW = ((RW > LEN_W) ? RW : LEN_W) + 1;

  logic [RW-1:0] run [WORD_W];

  always_comb begin
    logic             seen;
    logic [WORD_LOG-1:0] lb;
    for (int i = 0; i < WORD_W; i++) begin
      seen = 1'b0;
      lb   = '0;
      for (int j = 0; j <= i; j++) begin
        if (busy[j]) begin
          seen = 1'b1;
          lb   = WORD_LOG'(j);
        end
      end
      if (!seen) begin
        run[i] = RW'(carry_in) + RW'(i + 1);
      end else begin
        run[i] = RW'(i) - RW'(lb);
      end
    end
  end

  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (CMPW'(run[i]) >= CMPW'(want)) begin
        found     = 1'b1;
        found_bit = WORD_LOG'(i);
      end
    end
  end

  assign carry_out = CNTW'(run[WORD_W-1]);

endmodule
